>>> design/iqpas_pkg.sv
// Shared constants for the IQ pulse amplitude scaler.
`timescale 1ns / 1ps
`default_nettype none
package iqpas_pkg;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int GAIN_W          = 8;
  localparam int GAIN2_W         = 2 * GAIN_W;
  localparam int GAIN4_W         = 4 * GAIN_W;
  localparam int HEIGHT_W        = 16;
  localparam int AMP_W           = 36;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
endpackage
`default_nettype wire

>>> design/iqpas_front.sv
// Offset removal, squaring and gain product stages forming the radicand.
`timescale 1ns / 1ps
`default_nettype none
module iqpas_front import iqpas_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int RAD_W       = 2 * SAMPLE_BITS + 1 + GAIN4_W + 2 * FRAC_BITS + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [SAMPLE_BITS-1:0] cos_sample,
  input  wire logic [SAMPLE_BITS-1:0] sin_sample,
  input  wire logic [GAIN_W-1:0]      gain_a,
  input  wire logic [GAIN_W-1:0]      gain_b,
  output logic                        out_valid,
  output logic [RAD_W-1:0]            radicand
);
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int P_W   = SUM_W + GAIN4_W;
  localparam logic [SAMPLE_BITS-1:0] MID = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [2:0]             v_r;
  logic [SAMPLE_BITS-1:0] dc_r, ds_r;
  logic [GAIN2_W-1:0]     g_r;
  logic [SUM_W-1:0]       sum_r;
  logic [GAIN4_W-1:0]     g2_r;
  logic [P_W-1:0]         p_r;
  logic [SAMPLE_BITS-1:0] dc_nxt, ds_nxt;
  logic [GAIN_W-1:0]      ga_eff, gb_eff;
  logic [SQ_W-1:0]        sqc, sqs;
  logic [P_W-1:0]         p_nxt;

  always_comb begin
    dc_nxt = (cos_sample >= MID) ? cos_sample - MID : MID - cos_sample;
    ds_nxt = (sin_sample >= MID) ? sin_sample - MID : MID - sin_sample;
    ga_eff = (gain_a == '0) ? GAIN_W'(1) : gain_a;
    gb_eff = (gain_b == '0) ? GAIN_W'(1) : gain_b;
    sqc    = SQ_W'(dc_r) * SQ_W'(dc_r);
    sqs    = SQ_W'(ds_r) * SQ_W'(ds_r);
    p_nxt  = P_W'(sum_r) * P_W'(g2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r  <= dc_nxt;
      ds_r  <= ds_nxt;
      g_r   <= GAIN2_W'(ga_eff) * GAIN2_W'(gb_eff);
      sum_r <= SUM_W'(sqc) + SUM_W'(sqs);
      g2_r  <= GAIN4_W'(g_r) * GAIN4_W'(g_r);
      p_r   <= p_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign radicand  = RAD_W'(p_r) << (2 * FRAC_BITS);
endmodule
`default_nettype wire

>>> design/iqpas_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module iqpas_sqrt import iqpas_pkg::*; #(
  parameter int ROOT_W = 37
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       out_valid,
  output logic [ROOT_W-1:0]          root
);
  logic [ROOT_W:0]     v_r;
  logic [ROOT_W:0]     rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]   root_r [0:ROOT_W];
  logic [2*ROOT_W-1:0] rad_r  [0:ROOT_W];

  always_comb begin
    v_r[0]    = in_valid;
    rem_r[0]  = '0;
    root_r[0] = '0;
    rad_r[0]  = radicand;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+2:0] cur, trial;
    logic              take;
    always_comb begin
      cur   = {rem_r[k], rad_r[k][2*ROOT_W-1 -: 2]};
      trial = {1'b0, root_r[k], 2'b01};
      take  = (cur >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? (ROOT_W+1)'(cur - trial) : (ROOT_W+1)'(cur);
        root_r[k+1] <= {root_r[k][ROOT_W-2:0], take};
        rad_r[k+1]  <= rad_r[k] << 2;
      end
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign root      = root_r[ROOT_W];
endmodule
`default_nettype wire

>>> design/iqpas_div.sv
// Pipelined restoring divider by the height, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module iqpas_div import iqpas_pkg::*; #(
  parameter int Q_W = 37
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [Q_W-1:0]      dividend,
  input  wire logic [HEIGHT_W-1:0] divisor,
  output logic                     out_valid,
  output logic [Q_W-1:0]           quotient
);
  logic [Q_W:0]          v_r;
  logic [HEIGHT_W-1:0]   rem_r [0:Q_W];
  logic [Q_W-1:0]        dq_r  [0:Q_W];

  always_comb begin
    v_r[0]   = in_valid;
    rem_r[0] = '0;
    dq_r[0]  = dividend;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [HEIGHT_W:0] cur;
    logic              take;
    always_comb begin
      cur  = {rem_r[k], dq_r[k][Q_W-1]};
      take = (cur >= {1'b0, divisor});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? HEIGHT_W'(cur - {1'b0, divisor}) : HEIGHT_W'(cur);
        dq_r[k+1]  <= {dq_r[k][Q_W-2:0], take};
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign quotient  = dq_r[Q_W];
endmodule
`default_nettype wire

>>> design/iq_pulse_amplitude_scaler_unit.sv
// Top level of the IQ pulse amplitude scaler.
// Usage: each input item carries an offset-binary cosine and sine sample pair.
// The block removes the midpoint, forms the magnitude, scales it by both gain
// codes (a code of zero counts as one) and divides by the height register.
// The result carries FRAC_BITS fractional bits, truncated, and saturates.
// A height of zero gives an all-ones amplitude with the flag in out_tuser set.
// Configuration writes on the cfg_ port take effect at the next clock edge and
// must only happen while no item is in flight.
// An item passes through the front stages, the root stages, the divide stages and
// an output register, in that order; ROOT_W is half the radicand width rounded up.
// Throughput is one item per cycle while out_tready does not stall the output: the
// root and the divide each use one pipeline stage per result bit.
// When out_tready is low while a result waits, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
// Reset clears every valid bit and loads the registers with gains of zero and
// a height of one.
`timescale 1ns / 1ps
`default_nettype none
module iq_pulse_amplitude_scaler_unit import iqpas_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int IN_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // cos_sample, then sin_sample
  input  wire logic [IN_W-1:0]       in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // amplitude
  output logic [39:0]                out_tdata,
  // height_zero
  output logic                       out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int RAD_RAW = 2 * SAMPLE_BITS + 1 + GAIN4_W + 2 * FRAC_BITS;
  localparam int ROOT_W  = (RAD_RAW + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;

  logic [GAIN_W-1:0]   gain_a_r, gain_b_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                en;
  logic                fr_valid, sq_valid, dv_valid;
  logic [RAD_W-1:0]    radicand;
  logic [ROOT_W-1:0]   root, quot;
  logic                out_valid_r, hz_r;
  logic [AMP_W-1:0]    amp_r, amp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_a_r <= '0;
      gain_b_r <= '0;
      height_r <= HEIGHT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_A: gain_a_r <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_B: gain_b_r <= cfg_data[GAIN_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  iqpas_front #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .RAD_W(RAD_W)) u_front (
    .clk, .rst_n, .en,
    .in_valid  (in_tvalid),
    .cos_sample(in_tdata[SAMPLE_BITS-1:0]),
    .sin_sample(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .gain_a    (gain_a_r),
    .gain_b    (gain_b_r),
    .out_valid (fr_valid),
    .radicand  (radicand)
  );

  iqpas_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (fr_valid),
    .radicand (radicand),
    .out_valid(sq_valid),
    .root     (root)
  );

  iqpas_div #(.Q_W(ROOT_W)) u_div (
    .clk, .rst_n, .en,
    .in_valid (sq_valid),
    .dividend (root),
    .divisor  (height_r),
    .out_valid(dv_valid),
    .quotient (quot)
  );

  always_comb begin
    if (height_r == '0) begin
      amp_nxt = '1;
    end else if (ROOT_W > AMP_W && (quot >> AMP_W) != '0) begin
      amp_nxt = '1;
    end else begin
      amp_nxt = AMP_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amp_r <= amp_nxt;
      hz_r  <= (height_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, amp_r};
  assign out_tuser  = hz_r;

  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[AMP_W-1:0] == '1)
    else $error("height_zero without saturated amplitude");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

>>> sim/iq_pulse_amplitude_scaler_unit_test.sv
// Testbench for the IQ pulse amplitude scaler, checked against a predictor.
`timescale 1ns / 1ps
module iq_pulse_amplitude_scaler_unit_test;
  import iqpas_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [AMP_W-1:0] AMP_FULL = {AMP_W{1'b1}};

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic             zero;
  } amp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [GAIN_W-1:0]   gain_a_q = '0;
  logic [GAIN_W-1:0]   gain_b_q = '0;
  logic [HEIGHT_W-1:0] height_q = 16'd1;

  amp_result_t amp_expected_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  iq_pulse_amplitude_scaler_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [63:0] y;
    logic [127:0] c;
    y = '0;
    for (int b = 62; b >= 0; b--) begin
      c = {64'd0, y | (64'd1 << b)};
      if (c * c <= v) y = c[63:0];
    end
    return y;
  endfunction

  function automatic amp_result_t scaled_amplitude(logic [11:0] cs, logic [11:0] sn);
    amp_result_t r;
    logic [127:0] dc, ds, k, m, q;
    dc = (cs >= 12'd2048) ? cs - 12'd2048 : 12'd2048 - cs;
    ds = (sn >= 12'd2048) ? sn - 12'd2048 : 12'd2048 - sn;
    k = ((gain_a_q == 0) ? 128'd1 : gain_a_q) * ((gain_b_q == 0) ? 128'd1 : gain_b_q);
    k = k << FRAC_BITS_DEF;
    if (height_q == 0) begin
      r.amp = AMP_FULL;
      r.zero = 1'b1;
    end else begin
      m = root_floor((dc * dc + ds * ds) * (k * k));
      q = m / height_q;
      r.amp = (q > AMP_FULL) ? AMP_FULL : q[AMP_W-1:0];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) == 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    amp_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (amp_expected_q.size() == 0) begin
        $display("%0t: unexpected item amp=%h flag=%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_r = amp_expected_q.pop_front();
        if (out_tdata !== {4'd0, exp_r.amp} || out_tuser !== exp_r.zero) begin
          $display("%0t: expected amp=%h flag=%b, got amp=%h flag=%b",
                   $time, {4'd0, exp_r.amp}, exp_r.zero, out_tdata, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic send_pair(logic [11:0] cs, logic [11:0] sn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {sn, cs};
    do @(posedge clk); while (!in_tready);
    amp_expected_q = {amp_expected_q, scaled_amplitude(cs, sn)};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (amp_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN_A: gain_a_q = val[GAIN_W-1:0];
      CFG_GAIN_B: gain_b_q = val[GAIN_W-1:0];
      CFG_HEIGHT: height_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'(2048 + $urandom_range(0, 6) - 3);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_sample_extremes();
    send_pair(12'd2048, 12'd2048);
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd4095, 12'd2048);
    send_pair(12'd2047, 12'd2049);
    send_pair(12'd2048, 12'd0);
    send_pair(12'hAAA, 12'h555);
    wait_drained();
  endtask

  task automatic test_max_gain();
    write_reg(CFG_GAIN_A, 16'd255);
    write_reg(CFG_GAIN_B, 16'd255);
    write_reg(CFG_HEIGHT, 16'd1);
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd2049, 12'd2048);
    wait_drained();
    write_reg(CFG_HEIGHT, 16'hFFFF);
    send_pair(12'd0, 12'd0);
    send_pair(12'd2049, 12'd2047);
    wait_drained();
  endtask

  task automatic test_zero_height();
    write_reg(CFG_HEIGHT, 16'd0);
    send_pair(12'd2048, 12'd2048);
    send_pair(12'd0, 12'd4095);
    wait_drained();
  endtask

  task automatic test_wide_writes();
    // Bits above a gain width and the unused index must have no effect.
    write_reg(CFG_GAIN_A, 16'hFF03);
    write_reg(CFG_GAIN_B, 16'h0100);
    write_reg(CFG_HEIGHT, 16'd7);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_pair(12'd0, 12'd1000);
    send_pair(12'd3000, 12'd100);
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        wait_drained();
        write_reg(CFG_GAIN_A, 16'($urandom_range(0, 65535)));
        write_reg(CFG_GAIN_B, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 255)));
        case ($urandom_range(0, 4))
          0: write_reg(CFG_HEIGHT, 16'd0);
          1: write_reg(CFG_HEIGHT, 16'd1);
          2: write_reg(CFG_HEIGHT, 16'hFFFF);
          default: write_reg(CFG_HEIGHT, 16'($urandom_range(0, 65535)));
        endcase
      end
      if (i == 500) wait_drained();
      send_pair(rand_sample(), rand_sample());
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_sample_extremes();
    test_max_gain();
    test_zero_height();
    test_wide_writes();
    test_random(1100);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> iq_pulse_amplitude_scaler_unit.f
design/iqpas_pkg.sv
design/iqpas_front.sv
design/iqpas_sqrt.sv
design/iqpas_div.sv
design/iq_pulse_amplitude_scaler_unit.sv
sim/iq_pulse_amplitude_scaler_unit_test.sv
